@@ rtl/core/assert_macros.svh @@
// Assertion macros shared by the RTL that carries checks.
// Depends on nothing; the SYNTH define compiles the checks out.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define AGWS_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
`define AGWS_ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define AGWS_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define AGWS_ASSERT_NXT(label, clk, rst_n, ante, cons)
`endif
`endif

@@ rtl/core/agws_pkg.sv @@
// Shared types, codes and constants of the admission gate.
// Used by agws_front, agws_back and the top level.
package agws_pkg;

  localparam int MAX_WAITERS_DEF = 16;
  localparam int GRANTS_PER_PASS = 16;
  localparam int CMDQ_DEPTH      = 2;

  localparam logic [4:0]  CAP_RESET     = 5'd4;
  localparam logic [15:0] SPACING_RESET = 16'd1000;

  localparam logic [1:0] CFG_CAP     = 2'd0;
  localparam logic [1:0] CFG_SPACING = 2'd1;

  // input operation codes
  localparam logic [2:0] OP_REQ_ORD  = 3'd0;
  localparam logic [2:0] OP_REQ_HEAD = 3'd1;
  localparam logic [2:0] OP_CANCEL   = 3'd2;
  localparam logic [2:0] OP_REL_ORD  = 3'd3;
  localparam logic [2:0] OP_REL_HEAD = 3'd4;

  // classified command kinds
  localparam logic [2:0] CL_REQ_ORD  = 3'd0;
  localparam logic [2:0] CL_REQ_HEAD = 3'd1;
  localparam logic [2:0] CL_CANCEL   = 3'd2;
  localparam logic [2:0] CL_REL_ORD  = 3'd3;
  localparam logic [2:0] CL_REL_HEAD = 3'd4;
  localparam logic [2:0] CL_TICK     = 3'd5;

  localparam logic [1:0] OUT_ORD_GRANT  = 2'd0;
  localparam logic [1:0] OUT_HEAD_GRANT = 2'd1;
  localparam logic [1:0] OUT_STOPPED    = 2'd2;
  localparam logic [1:0] OUT_REJECT     = 2'd3;

  typedef struct packed {
    logic [2:0]  kind;
    logic [3:0]  id;
    logic [31:0] now;
  } cmd_t;

  typedef struct packed {
    logic [1:0] cnt;
  } front_stat_t;

  typedef struct packed {
    logic idle;
    logic pend_valid;
  } back_stat_t;

endpackage

@@ rtl/core/agws_front.sv @@
// Front end: takes input words, classifies the operation, queues commands.
// Depends on agws_pkg.
module agws_front (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  output logic                  busy,
  input  logic [2:0]            in_operation,
  input  logic [3:0]            in_waiter_id,
  input  logic [31:0]           in_now_ms,
  output logic                  cmd_valid,
  output agws_pkg::cmd_t        cmd,
  input  logic                  cmd_pop,
  output agws_pkg::front_stat_t fstat
);

  localparam int PW = $clog2(agws_pkg::CMDQ_DEPTH);
  localparam int CW = $clog2(agws_pkg::CMDQ_DEPTH + 1);

  agws_pkg::cmd_t fifo_r [agws_pkg::CMDQ_DEPTH];
  logic [PW-1:0]  wp_r, rp_r;
  logic [CW-1:0]  cnt_r;
  agws_pkg::cmd_t in_cmd;
  logic           push;

  always_comb begin
    in_cmd.id  = in_waiter_id;
    in_cmd.now = in_now_ms;
    case (in_operation)
      agws_pkg::OP_REQ_ORD:  in_cmd.kind = agws_pkg::CL_REQ_ORD;
      agws_pkg::OP_REQ_HEAD: in_cmd.kind = agws_pkg::CL_REQ_HEAD;
      agws_pkg::OP_CANCEL:   in_cmd.kind = agws_pkg::CL_CANCEL;
      agws_pkg::OP_REL_ORD:  in_cmd.kind = agws_pkg::CL_REL_ORD;
      agws_pkg::OP_REL_HEAD: in_cmd.kind = agws_pkg::CL_REL_HEAD;
      default:               in_cmd.kind = agws_pkg::CL_TICK;
    endcase
  end

  assign busy      = (cnt_r == CW'(agws_pkg::CMDQ_DEPTH));
  assign push      = start && !busy;
  assign cmd_valid = (cnt_r != '0);
  assign cmd       = fifo_r[rp_r];
  assign fstat.cnt = 2'(cnt_r);

  always_ff @(posedge clk) begin
    if (push) begin
      fifo_r[wp_r] <= in_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) begin
        wp_r <= (wp_r == PW'(agws_pkg::CMDQ_DEPTH - 1)) ? '0 : wp_r + 1'b1;
      end
      if (cmd_pop) begin
        rp_r <= (rp_r == PW'(agws_pkg::CMDQ_DEPTH - 1)) ? '0 : rp_r + 1'b1;
      end
      cnt_r <= cnt_r + CW'(push) - CW'(cmd_pop);
    end
  end

endmodule

@@ rtl/core/agws_back.sv @@
// Back end: waiter queues, permit counters and the iterative grant pass.
// Depends on agws_pkg; fed by agws_front.
module agws_back #(
  parameter int MAX_WAITERS = agws_pkg::MAX_WAITERS_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cmd_valid,
  input  agws_pkg::cmd_t       cmd,
  output logic                 cmd_pop,
  input  logic [4:0]           cap,
  input  logic [15:0]          spacing,
  output logic                 out_valid,
  output logic [3:0]           out_result_waiter,
  output logic [1:0]           out_outcome,
  output logic                 out_last_result,
  output agws_pkg::back_stat_t bstat
);

  localparam int CW = $clog2(MAX_WAITERS + 1);
  localparam int GW = $clog2(agws_pkg::GRANTS_PER_PASS + 1);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_PASS = 2'd1;
  localparam logic [1:0] S_END  = 2'd2;

  logic [3:0]    oq_r [MAX_WAITERS];
  logic [3:0]    oq_nxt [MAX_WAITERS];
  logic [3:0]    hq_r [MAX_WAITERS];
  logic [3:0]    hq_nxt [MAX_WAITERS];
  logic [CW-1:0] oc_r, oc_nxt, hc_r, hc_nxt;
  logic [15:0]   set_r, set_nxt;
  logic [4:0]    act_r, act_nxt;
  logic          hact_r, hact_nxt;
  logic [31:0]   lt_r, lt_nxt;
  logic          lv_r, lv_nxt;
  logic [1:0]    state_r, state_nxt;
  logic [GW-1:0] gr_r, gr_nxt;
  logic [31:0]   now_r, now_nxt;
  logic          pv_r, pv_nxt;
  logic [3:0]    pid_r, pid_nxt;
  logic [1:0]    poc_r, poc_nxt;
  logic          ov_r, ov_nxt, ol_r, ol_nxt;
  logic [3:0]    oid_r, oid_nxt;
  logic [1:0]    ooc_r, ooc_nxt;

  logic [MAX_WAITERS-1:0] o_set, h_set, o_pre, h_pre, o_hit, h_hit;
  logic        o_drop, h_drop, too_soon;
  logic        res_v;
  logic [3:0]  res_id;
  logic [1:0]  res_oc;

  // settled-entry scan and cancel lookup over both queues
  always_comb begin
    for (int j = 0; j < MAX_WAITERS; j++) begin
      o_set[j] = (CW'(j) < oc_r) && set_r[oq_r[j]];
      h_set[j] = (CW'(j) < hc_r) && set_r[hq_r[j]];
      o_hit[j] = (CW'(j) < oc_r) && (oq_r[j] == cmd.id);
      h_hit[j] = (CW'(j) < hc_r) && (hq_r[j] == cmd.id);
    end
    o_pre[0] = o_set[0];
    h_pre[0] = h_set[0];
    for (int j = 1; j < MAX_WAITERS; j++) begin
      o_pre[j] = o_pre[j-1] | o_set[j];
      h_pre[j] = h_pre[j-1] | h_set[j];
    end
  end

  assign o_drop   = |o_set;
  assign h_drop   = |h_set;
  assign too_soon = lv_r && ((now_r - lt_r) < {16'd0, spacing});
  assign cmd_pop  = (state_r == S_IDLE) && cmd_valid;

  always_comb begin
    oq_nxt    = oq_r;
    hq_nxt    = hq_r;
    oc_nxt    = oc_r;
    hc_nxt    = hc_r;
    set_nxt   = set_r;
    act_nxt   = act_r;
    hact_nxt  = hact_r;
    lt_nxt    = lt_r;
    lv_nxt    = lv_r;
    state_nxt = state_r;
    gr_nxt    = gr_r;
    now_nxt   = now_r;
    pv_nxt    = pv_r;
    pid_nxt   = pid_r;
    poc_nxt   = poc_r;
    ov_nxt    = 1'b0;
    ol_nxt    = 1'b0;
    oid_nxt   = oid_r;
    ooc_nxt   = ooc_r;
    res_v     = 1'b0;
    res_id    = cmd.id;
    res_oc    = agws_pkg::OUT_REJECT;

    case (state_r)
      S_IDLE: begin
        if (cmd_valid) begin
          now_nxt   = cmd.now;
          gr_nxt    = '0;
          state_nxt = S_PASS;
          case (cmd.kind)
            agws_pkg::CL_REQ_ORD: begin
              if (oc_r == CW'(MAX_WAITERS)) begin
                res_v = 1'b1;
              end else begin
                for (int j = 0; j < MAX_WAITERS; j++) begin
                  if (CW'(j) == oc_r) oq_nxt[j] = cmd.id;
                end
                oc_nxt          = oc_r + 1'b1;
                set_nxt[cmd.id] = 1'b0;
              end
            end
            agws_pkg::CL_REQ_HEAD: begin
              if (hc_r == CW'(MAX_WAITERS)) begin
                res_v = 1'b1;
              end else begin
                for (int j = 0; j < MAX_WAITERS; j++) begin
                  if (CW'(j) == hc_r) hq_nxt[j] = cmd.id;
                end
                hc_nxt          = hc_r + 1'b1;
                set_nxt[cmd.id] = 1'b0;
              end
            end
            agws_pkg::CL_CANCEL: begin
              if (!set_r[cmd.id] && ((|o_hit) || (|h_hit))) begin
                set_nxt[cmd.id] = 1'b1;
                res_v           = 1'b1;
                res_oc          = agws_pkg::OUT_STOPPED;
              end
            end
            agws_pkg::CL_REL_ORD: begin
              if (act_r != '0) act_nxt = act_r - 1'b1;
            end
            agws_pkg::CL_REL_HEAD: begin
              hact_nxt = 1'b0;
            end
            default: ;
          endcase
        end
      end
      S_PASS: begin
        if (o_drop || h_drop) begin
          // remove the first settled entry of each queue
          if (o_drop) begin
            for (int j = 0; j < MAX_WAITERS - 1; j++) begin
              if (o_pre[j]) oq_nxt[j] = oq_r[j+1];
            end
            oc_nxt = oc_r - 1'b1;
          end
          if (h_drop) begin
            for (int j = 0; j < MAX_WAITERS - 1; j++) begin
              if (h_pre[j]) hq_nxt[j] = hq_r[j+1];
            end
            hc_nxt = hc_r - 1'b1;
          end
        end else if (hc_r != '0) begin
          if ((act_r != '0) || hact_r || too_soon) begin
            state_nxt = S_END;
          end else begin
            for (int j = 0; j < MAX_WAITERS - 1; j++) hq_nxt[j] = hq_r[j+1];
            hc_nxt           = hc_r - 1'b1;
            set_nxt[hq_r[0]] = 1'b1;
            hact_nxt         = 1'b1;
            lt_nxt           = now_r;
            lv_nxt           = 1'b1;
            res_v            = 1'b1;
            res_id           = hq_r[0];
            res_oc           = agws_pkg::OUT_HEAD_GRANT;
            gr_nxt           = gr_r + 1'b1;
            if (gr_r == GW'(agws_pkg::GRANTS_PER_PASS - 1)) state_nxt = S_END;
          end
        end else if (oc_r != '0) begin
          if (hact_r || (act_r >= cap) || too_soon) begin
            state_nxt = S_END;
          end else begin
            for (int j = 0; j < MAX_WAITERS - 1; j++) oq_nxt[j] = oq_r[j+1];
            oc_nxt           = oc_r - 1'b1;
            set_nxt[oq_r[0]] = 1'b1;
            act_nxt          = act_r + 1'b1;
            lt_nxt           = now_r;
            lv_nxt           = 1'b1;
            res_v            = 1'b1;
            res_id           = oq_r[0];
            res_oc           = agws_pkg::OUT_ORD_GRANT;
            gr_nxt           = gr_r + 1'b1;
            if (gr_r == GW'(agws_pkg::GRANTS_PER_PASS - 1)) state_nxt = S_END;
          end
        end else begin
          state_nxt = S_END;
        end
      end
      S_END: begin
        if (pv_r) begin
          ov_nxt  = 1'b1;
          ol_nxt  = 1'b1;
          oid_nxt = pid_r;
          ooc_nxt = poc_r;
        end
        pv_nxt    = 1'b0;
        state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase

    // one result held back so the final one can carry the last flag
    if (res_v) begin
      if (pv_r) begin
        ov_nxt  = 1'b1;
        oid_nxt = pid_r;
        ooc_nxt = poc_r;
      end
      pv_nxt  = 1'b1;
      pid_nxt = res_id;
      poc_nxt = res_oc;
    end
  end

  always_ff @(posedge clk) begin
    oq_r  <= oq_nxt;
    hq_r  <= hq_nxt;
    lt_r  <= lt_nxt;
    gr_r  <= gr_nxt;
    now_r <= now_nxt;
    pid_r <= pid_nxt;
    poc_r <= poc_nxt;
    oid_r <= oid_nxt;
    ooc_r <= ooc_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      oc_r    <= '0;
      hc_r    <= '0;
      set_r   <= '0;
      act_r   <= '0;
      hact_r  <= 1'b0;
      lv_r    <= 1'b0;
      state_r <= S_IDLE;
      pv_r    <= 1'b0;
      ov_r    <= 1'b0;
      ol_r    <= 1'b0;
    end else begin
      oc_r    <= oc_nxt;
      hc_r    <= hc_nxt;
      set_r   <= set_nxt;
      act_r   <= act_nxt;
      hact_r  <= hact_nxt;
      lv_r    <= lv_nxt;
      state_r <= state_nxt;
      pv_r    <= pv_nxt;
      ov_r    <= ov_nxt;
      ol_r    <= ol_nxt;
    end
  end

  assign out_valid         = ov_r;
  assign out_result_waiter = oid_r;
  assign out_outcome       = ooc_r;
  assign out_last_result   = ol_r;
  assign bstat.idle        = (state_r == S_IDLE);
  assign bstat.pend_valid  = pv_r;

endmodule

@@ rtl/core/admission_gate_with_spacing_top.sv @@
// Admission gate top: front classifier, two-word command queue, grant back end.
// Back end per word: apply the command, then drop settled entries (one off each queue per step),
// grant waiters, find the pass done (skipped after a 16th grant), then close.
// Throughput: one word per back-end pass; busy rises when the command queue is full.
// Results are registered: each leaves the cycle after the next is found or the close.
// Sync active-low reset empties queues, counters, grant history; results cannot stall.
`include "assert_macros.svh"
module admission_gate_with_spacing_top #(
  parameter int MAX_WAITERS = agws_pkg::MAX_WAITERS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [2:0]  in_operation,
  input  logic [3:0]  in_waiter_id,
  input  logic [31:0] in_now_ms,
  output logic        out_valid,
  output logic [3:0]  out_result_waiter,
  output logic [1:0]  out_outcome,
  output logic        out_last_result,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  // configuration registers, writes apply at once; hosts must write between words, unenforced
  logic [4:0]  cap_r;
  logic [15:0] spacing_r;

  agws_pkg::cmd_t        cmd;
  logic                  cmd_valid, cmd_pop;
  agws_pkg::front_stat_t fstat;
  agws_pkg::back_stat_t  bstat;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r     <= agws_pkg::CAP_RESET;
      spacing_r <= agws_pkg::SPACING_RESET;
    end else if (cfg_valid) begin
      case (cfg_index)
        agws_pkg::CFG_CAP:     cap_r     <= cfg_data[4:0];
        agws_pkg::CFG_SPACING: spacing_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // front: accept word, decode op, hold it in the command queue
  agws_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .busy         (busy),
    .in_operation (in_operation),
    .in_waiter_id (in_waiter_id),
    .in_now_ms    (in_now_ms),
    .cmd_valid    (cmd_valid),
    .cmd          (cmd),
    .cmd_pop      (cmd_pop),
    .fstat        (fstat)
  );

  // back: apply command, then run the grant pass one step per cycle
  agws_back #(
    .MAX_WAITERS (MAX_WAITERS)
  ) u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd_valid         (cmd_valid),
    .cmd               (cmd),
    .cmd_pop           (cmd_pop),
    .cap               (cap_r),
    .spacing           (spacing_r),
    .out_valid         (out_valid),
    .out_result_waiter (out_result_waiter),
    .out_outcome       (out_outcome),
    .out_last_result   (out_last_result),
    .bstat             (bstat)
  );

  // the closing result of a word is never followed directly by another
  `AGWS_ASSERT_NXT(a_last_gap, clk, rst_n, out_valid && out_last_result, !out_valid)
  // held-back result is flushed before the back end goes idle
  `AGWS_ASSERT_IMP(a_idle_flushed, clk, rst_n, bstat.idle, !bstat.pend_valid)
  // an accepted word is in the command queue on the next cycle
  `AGWS_ASSERT_NXT(a_word_queued, clk, rst_n, start && !busy, fstat.cnt != 2'd0)

endmodule
